[rtl/rfpq_pkg.sv]
// Package for the reference-counted frame pool queue.
// Holds pool sizes, operation and status codes and the state machine type; no dependencies.
package rfpq_pkg;

   // pool, ring and count sizes
   localparam int POOL_SLOTS  = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int REF_BITS    = 8;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_PUSH    = 3'd1,
      OP_CONS_Q  = 3'd2,
      OP_CONS_L  = 3'd3,
      OP_ADDREF  = 3'd4,
      OP_RELEASE = 3'd5,
      OP_CLEAR   = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SHOW
   } fsm_type;

   localparam int CSR_POOL_IN_USE = 0;
   localparam int CSR_QUEUE_SLOTS = 1;

endpackage

[rtl/rfpq_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rfpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/refcounted_frame_pool_queue.sv]
// Reference-counted frame pool with a ring queue of slot indices.
// Flow: a request is accepted in idle and its RAM read issued; the execute state then writes
// back and registers the response, which the show state presents (a FIFO consume first
// spends an extra execute pass reading the ring entry before the count). A new request is
// held off until the response is taken and the block is back in idle.
// Reset clears counts and stored ids (per-slot valid bits), queue, latest pointer, id counter.
module refcounted_frame_pool_queue
   import rfpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_frame_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_frame_valid,
   output logic [3:0]  rsp_frame_index_out,
   output logic [31:0] rsp_slot_id,
   output logic [7:0]  rsp_ref_count,
   output logic [4:0]  rsp_free_count,
   output logic        rsp_enqueued,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_data
);

   localparam int PB = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int QB = $clog2(QUEUE_DEPTH);
   localparam int CB = $clog2(POOL_SLOTS + 1);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   fsm_type state_ff, state_in;

   logic [4:0] pool_cfg_ff, ring_cfg_ff;
   logic [QB-1:0] head_ff, tail_ff;
   logic [PB-1:0] latest_ff;
   logic latest_ok_ff;
   logic [CB-1:0] free_ff;
   logic [31:0] id_ctr_ff;
   logic [POOL_SLOTS-1:0] ref_live_ff;   // count written since reset or clear (RAM content valid)
   logic [POOL_SLOTS-1:0] busy_ff;       // count nonzero, for allocation search
   logic [POOL_SLOTS-1:0] id_live_ff;    // id written since reset

   op_type op_ff;
   logic [3:0] idx_ff;

   logic [1:0] r_status_ff;
   logic r_fv_ff, r_enq_ff;
   logic [3:0] r_idx_ff;
   logic [31:0] r_id_ff;
   logic [7:0] r_ref_ff;
   logic [4:0] r_free_ff;

   // effective sizes
   logic [CB-1:0] pool_eff;
   logic [4:0] ring_eff;
   always_comb begin
      if (pool_cfg_ff == 5'd0) pool_eff = CB'(1);
      else if (32'(pool_cfg_ff) > POOL_SLOTS) pool_eff = CB'(POOL_SLOTS);
      else pool_eff = CB'(pool_cfg_ff);
      if (ring_cfg_ff < 5'd2) ring_eff = 5'd2;
      else if (32'(ring_cfg_ff) > QUEUE_DEPTH) ring_eff = 5'(QUEUE_DEPTH);
      else ring_eff = ring_cfg_ff;
   end

   // ring read address selection in accept cycle
   logic accept;
   assign accept = (state_ff == FSM_IDLE) && req_valid && !csr_write;

   // slot chosen for the read
   logic [PB-1:0] first_free;
   logic any_free;
   always_comb begin
      first_free = '0;
      any_free = 1'b0;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i] && i < int'(pool_eff)) begin
            first_free = PB'(i);
            any_free = 1'b1;
         end
      end
   end

   // queue entry and memories
   logic [3:0] ring_rd;
   logic ring_we;
   logic [QB-1:0] ring_wa;
   rfpq_ram #(.WIDTH(4), .DEPTH(QUEUE_DEPTH)) u_ring (
      .clock(clock), .wr_en(ring_we), .wr_addr(ring_wa), .wr_data(idx_ff),
      .rd_addr(head_ff), .rd_data(ring_rd)
   );

   // slot address: in EXEC, FIFO consume uses the ring output
   logic [PB-1:0] slot_rd_a, slot_x;
   logic slot_we, id_we;
   logic [REF_BITS-1:0] ref_rd, ref_wd, ref_cur;
   logic [31:0] id_rd;
   always_comb begin
      unique case (op_type'(req_mode))
         OP_ALLOC:  slot_rd_a = first_free;
         OP_CONS_L: slot_rd_a = latest_ff;
         default:   slot_rd_a = PB'(req_frame_index);
      endcase
   end

   // references RAM read at accept (except FIFO consume, re-read in a second pass)
   logic [PB-1:0] ref_ra;
   logic [PB-1:0] slot_hold_ff;
   logic fetch_ff;                       // FIFO consume needs second read
   assign ref_ra = (state_ff == FSM_IDLE) ? slot_rd_a : PB'(ring_rd);
   rfpq_ram #(.WIDTH(REF_BITS), .DEPTH(POOL_SLOTS)) u_refs (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_x), .wr_data(ref_wd),
      .rd_addr(ref_ra), .rd_data(ref_rd)
   );
   rfpq_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_ids (
      .clock(clock), .wr_en(id_we), .wr_addr(slot_x), .wr_data(id_ctr_ff + 32'd1),
      .rd_addr(ref_ra), .rd_data(id_rd)
   );

   assign slot_x = slot_hold_ff;
   assign ref_cur = ref_live_ff[slot_x] ? ref_rd : '0;

   // decide the operation in the EXEC cycle
   logic pool_bad, q_empty, q_full, do_cons;
   logic [QB-1:0] tail_nx, head_nx;
   always_comb begin
      pool_bad = {1'b0, idx_ff} >= 5'(pool_eff);
      q_empty = head_ff == tail_ff;
      tail_nx = (5'(tail_ff) + 5'd1 == ring_eff) ? '0 : QB'(5'(tail_ff) + 5'd1);
      head_nx = (5'(head_ff) + 5'd1 == ring_eff) ? '0 : QB'(5'(head_ff) + 5'd1);
      q_full = tail_nx == head_ff;
      do_cons = (op_ff == OP_CONS_Q && !q_empty) || (op_ff == OP_CONS_L && latest_ok_ff)
                || (op_ff == OP_ADDREF && !pool_bad);
   end

   logic exec;
   assign exec = (state_ff == FSM_EXEC) && !fetch_ff;

   always_comb begin
      slot_we = 1'b0;
      id_we = 1'b0;
      ref_wd = ref_cur;
      ring_we = exec && op_ff == OP_PUSH && !pool_bad && !q_full;
      ring_wa = tail_ff;
      if (exec) begin
         unique case (op_ff)
            OP_ALLOC: begin
               slot_we = free_ff != '0 && any_free;
               id_we = slot_we;
               ref_wd = REF_BITS'(1);
            end
            OP_CONS_Q, OP_CONS_L, OP_ADDREF: begin
               slot_we = do_cons && ref_cur != REF_MAX;
               ref_wd = ref_cur + REF_BITS'(1);
            end
            OP_RELEASE: begin
               slot_we = !pool_bad && ref_cur != '0;
               ref_wd = ref_cur - REF_BITS'(1);
            end
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (accept) state_in = FSM_EXEC;
         FSM_EXEC: if (!fetch_ff) state_in = FSM_SHOW;
         FSM_SHOW: if (!rsp_stall) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // outputs; hold requests off while busy or while a register write is in progress
   always_comb begin
      req_stall = state_ff != FSM_IDLE || csr_write;
      rsp_valid = state_ff == FSM_SHOW;
      rsp_status = r_status_ff;
      rsp_frame_valid = r_fv_ff;
      rsp_frame_index_out = r_idx_ff;
      rsp_slot_id = r_id_ff;
      rsp_ref_count = r_ref_ff;
      rsp_free_count = r_free_ff;
      rsp_enqueued = r_enq_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         pool_cfg_ff <= 5'd16;
         ring_cfg_ff <= 5'd16;
         head_ff <= '0;
         tail_ff <= '0;
         latest_ok_ff <= 1'b0;
         latest_ff <= '0;
         free_ff <= CB'((POOL_SLOTS < 16) ? POOL_SLOTS : 16);
         id_ctr_ff <= '0;
         ref_live_ff <= '0;
         busy_ff <= '0;
         id_live_ff <= '0;
         fetch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            // register write clears, using the new pool size
            if (csr_index == 1'(CSR_POOL_IN_USE)) begin
               pool_cfg_ff <= csr_data;
               if (csr_data == 5'd0) free_ff <= CB'(1);
               else if (32'(csr_data) > POOL_SLOTS) free_ff <= CB'(POOL_SLOTS);
               else free_ff <= CB'(csr_data);
            end else begin
               ring_cfg_ff <= csr_data;
               free_ff <= pool_eff;
            end
            head_ff <= '0;
            tail_ff <= '0;
            latest_ok_ff <= 1'b0;
            ref_live_ff <= '0;
            busy_ff <= '0;
         end
         if (accept) fetch_ff <= op_type'(req_mode) == OP_CONS_Q;
         else if (state_ff == FSM_EXEC) fetch_ff <= 1'b0;
         if (exec) begin
            unique case (op_ff)
               OP_ALLOC: if (slot_we) begin
                  id_ctr_ff <= id_ctr_ff + 32'd1;
                  free_ff <= free_ff - CB'(1);
                  ref_live_ff[slot_x] <= 1'b1;
                  busy_ff[slot_x] <= 1'b1;
                  id_live_ff[slot_x] <= 1'b1;
               end
               OP_PUSH: if (!pool_bad) begin
                  if (!q_full) tail_ff <= tail_nx;
                  latest_ff <= PB'(idx_ff);
                  latest_ok_ff <= 1'b1;
               end
               OP_CONS_Q, OP_CONS_L, OP_ADDREF: begin
                  if (op_ff == OP_CONS_Q && !q_empty) head_ff <= head_nx;
                  if (slot_we) begin
                     ref_live_ff[slot_x] <= 1'b1;
                     busy_ff[slot_x] <= 1'b1;
                  end
               end
               OP_RELEASE: if (slot_we && ref_wd == '0) begin
                  busy_ff[slot_x] <= 1'b0;
                  if (free_ff < pool_eff) free_ff <= free_ff + CB'(1);
               end
               OP_CLEAR: begin
                  head_ff <= '0;
                  tail_ff <= '0;
                  latest_ok_ff <= 1'b0;
                  ref_live_ff <= '0;
                  busy_ff <= '0;
                  free_ff <= pool_eff;
               end
               default: ;
            endcase
         end
      end
   end

   // request capture and response registers
   logic [1:0] st;
   logic fv;
   logic [REF_BITS-1:0] ref_out;
   logic [31:0] id_out;
   logic [CB-1:0] free_out;
   always_comb begin
      st = ST_OK;
      fv = 1'b0;
      ref_out = ref_cur;
      id_out = id_live_ff[slot_x] ? id_rd : 32'd0;
      free_out = free_ff;
      unique case (op_ff)
         OP_ALLOC: begin
            if (slot_we) begin
               fv = 1'b1; ref_out = REF_BITS'(1); id_out = id_ctr_ff + 32'd1;
               free_out = free_ff - CB'(1);
            end else st = ST_NO_FREE;
         end
         OP_PUSH: begin
            if (pool_bad) st = ST_INVALID; else fv = 1'b1;
         end
         OP_CONS_Q, OP_CONS_L, OP_ADDREF: begin
            if (op_ff == OP_ADDREF && pool_bad) st = ST_INVALID;
            else if (do_cons) begin
               fv = 1'b1;
               if (slot_we) ref_out = ref_wd; else st = ST_INVALID;
            end
         end
         OP_RELEASE: begin
            if (pool_bad) st = ST_INVALID;
            else begin
               fv = 1'b1;
               if (slot_we) begin
                  ref_out = ref_wd;
                  if (ref_wd == '0 && free_ff < pool_eff) free_out = free_ff + CB'(1);
               end else st = ST_INVALID;
            end
         end
         OP_CLEAR: free_out = pool_eff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_mode);
         idx_ff <= req_frame_index;
         slot_hold_ff <= slot_rd_a;
      end
      if (state_ff == FSM_EXEC && fetch_ff) slot_hold_ff <= PB'(ring_rd);
      if (exec) begin
         r_status_ff <= st;
         r_fv_ff <= fv;
         r_idx_ff <= fv ? 4'(slot_x) : 4'd0;
         r_id_ff <= fv ? id_out : 32'd0;
         r_ref_ff <= fv ? 8'(ref_out) : 8'd0;
         r_free_ff <= 5'(free_out);
         r_enq_ff <= op_ff == OP_PUSH && !pool_bad && !q_full;
      end
   end

endmodule

[tb/refcounted_frame_pool_queue_tb.sv]
// Self-checking testbench for the reference-counted frame pool queue.
// Drives requests and register writes, predicts each response; depends on rfpq_pkg.
`timescale 1ns / 100ps

module refcounted_frame_pool_queue_tb;
   import rfpq_pkg::*;

   localparam int NSLOT   = 16;
   localparam int NQUEUE  = 16;
   localparam int REF_TOP = 255;

   typedef struct packed {
      op_type     mode;
      logic [3:0] idx;
   } pool_req_type;

   typedef struct packed {
      status_type  status;
      logic        fvalid;
      logic [3:0]  fidx;
      logic [31:0] fid;
      logic [7:0]  refs;
      logic [4:0]  free_n;
      logic        enq;
   } pool_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [3:0]  req_frame_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_frame_valid;
   logic [3:0]  rsp_frame_index_out;
   logic [31:0] rsp_slot_id;
   logic [7:0]  rsp_ref_count;
   logic [4:0]  rsp_free_count;
   logic        rsp_enqueued;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [4:0]  csr_data = '0;

   // Predicted pool state
   logic [7:0]  m_refs [NSLOT];
   logic [31:0] m_ids [NSLOT];
   logic [3:0]  m_ring [NQUEUE];
   int unsigned m_head, m_tail, m_latest, m_free;
   bit          m_latest_ok;
   logic [31:0] m_idctr;
   logic [4:0]  m_pool_reg, m_ring_reg;

   pool_req_type pending_reqs[$];
   pool_rsp_type expected_rsps[$];
   int          errors = 0;
   int          req_gap = 0, rsp_gap = 0;
   bit          quiet = 1'b0;
   bit          hold_off = 1'b0;

   refcounted_frame_pool_queue u_top (.*);

   always #1 clock = ~clock;

   function automatic int unsigned pool_eff();
      if (m_pool_reg < 1) return 1;
      if (m_pool_reg > NSLOT) return NSLOT;
      return 32'(m_pool_reg);
   endfunction

   function automatic int unsigned ring_eff();
      if (m_ring_reg < 2) return 2;
      if (m_ring_reg > NQUEUE) return NQUEUE;
      return 32'(m_ring_reg);
   endfunction

   function automatic void pool_clear();
      m_head = 0;
      m_tail = 0;
      m_latest = 0;
      m_latest_ok = 1'b0;
      foreach (m_refs[i]) m_refs[i] = '0;
      m_free = pool_eff();
   endfunction

   // Work out the response of one request and advance the pool state
   function automatic pool_rsp_type pool_apply(pool_req_type r);
      pool_rsp_type o;
      int unsigned pool, rs, s, nt;
      bit          ok;
      pool = pool_eff();
      rs = ring_eff();
      s = 0;
      ok = 1'b0;
      o = '0;
      o.status = ST_OK;
      case (r.mode)
         OP_ALLOC: begin
            o.status = ST_NO_FREE;
            if (m_free != 0) begin
               for (int i = 0; i < pool; i++) begin
                  if (m_refs[i] == 0) begin
                     m_idctr++;
                     m_refs[i] = 8'd1;
                     m_ids[i] = m_idctr;
                     m_free--;
                     o.status = ST_OK;
                     ok = 1'b1;
                     s = i;
                     break;
                  end
               end
            end
         end
         OP_PUSH: begin
            if (r.idx >= pool) o.status = ST_INVALID;
            else begin
               nt = (m_tail + 1) % rs;
               if (nt != m_head) begin
                  m_ring[m_tail] = r.idx;
                  m_tail = nt;
                  o.enq = 1'b1;
               end
               m_latest = 32'(r.idx);
               m_latest_ok = 1'b1;
               ok = 1'b1;
               s = 32'(r.idx);
            end
         end
         OP_CONS_Q, OP_CONS_L, OP_ADDREF: begin
            if (r.mode == OP_CONS_Q && m_head != m_tail) begin
               s = 32'(m_ring[m_head]);
               m_head = (m_head + 1) % rs;
               ok = 1'b1;
            end else if (r.mode == OP_CONS_L && m_latest_ok) begin
               s = m_latest;
               ok = 1'b1;
            end else if (r.mode == OP_ADDREF) begin
               if (r.idx >= pool) o.status = ST_INVALID;
               else begin
                  s = 32'(r.idx);
                  ok = 1'b1;
               end
            end
            if (ok) begin
               if (m_refs[s] >= REF_TOP) o.status = ST_INVALID;
               else m_refs[s]++;
            end
         end
         OP_RELEASE: begin
            if (r.idx >= pool) o.status = ST_INVALID;
            else begin
               s = 32'(r.idx);
               ok = 1'b1;
               if (m_refs[s] == 0) o.status = ST_INVALID;
               else begin
                  m_refs[s]--;
                  if (m_refs[s] == 0 && m_free < pool) m_free++;
               end
            end
         end
         OP_CLEAR: pool_clear();
         default: ;
      endcase
      o.fvalid = ok;
      if (ok) begin
         o.fidx = 4'(s);
         o.fid = m_ids[s];
         o.refs = m_refs[s];
      end
      o.free_n = 5'(m_free);
      return o;
   endfunction

   // Driver: present the next request, honour the stall
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(pool_apply(pending_reqs.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (hold_off || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               // present the oldest pending request
               req_valid <= 1'b1;
               req_mode <= pending_reqs[0].mode;
               req_frame_index <= pending_reqs[0].idx;
               if (!quiet && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 14);
            end
         end
      end
   end

   // Monitor: compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      pool_rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); errors++;
               end
               if (rsp_frame_valid !== e.fvalid) begin
                  $error("frame_valid exp %0d got %0d", e.fvalid, rsp_frame_valid); errors++;
               end
               if (rsp_frame_index_out !== e.fidx) begin
                  $error("frame_index_out exp %0d got %0d", e.fidx, rsp_frame_index_out);
                  errors++;
               end
               if (rsp_slot_id !== e.fid) begin
                  $error("slot_id exp %0d got %0d", e.fid, rsp_slot_id); errors++;
               end
               if (rsp_ref_count !== e.refs) begin
                  $error("ref_count exp %0d got %0d", e.refs, rsp_ref_count); errors++;
               end
               if (rsp_free_count !== e.free_n) begin
                  $error("free_count exp %0d got %0d", e.free_n, rsp_free_count); errors++;
               end
               if (rsp_enqueued !== e.enq) begin
                  $error("enqueued exp %0d got %0d", e.enq, rsp_enqueued); errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_req(op_type m, int unsigned i);
      pool_req_type r;
      r.mode = m;
      r.idx = 4'(i);
      pending_reqs.push_back(r);
   endtask

   // Wait until every queued request is done and the block is quiet
   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_set(int idx, logic [4:0] val);
      csr_write <= 1'b1;
      csr_index <= 1'(idx);
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_POOL_IN_USE) m_pool_reg = val;
      else m_ring_reg = val;
      pool_clear();
   endtask

   // Mostly well-formed lifecycles: allocate, push, consume, add-reference, release, clear, no-op
   task automatic random_batch(int n);
      int unsigned k, hi;
      for (int j = 0; j < n; j++) begin
         k = $urandom_range(0, 99);
         hi = (k < 5) ? 15 : pool_eff() - 1;
         if (k < 22) add_req(OP_ALLOC, $urandom_range(0, 15));
         else if (k < 40) add_req(OP_PUSH, $urandom_range(0, hi));
         else if (k < 52) add_req(OP_CONS_Q, $urandom_range(0, 15));
         else if (k < 60) add_req(OP_CONS_L, $urandom_range(0, 15));
         else if (k < 70) add_req(OP_ADDREF, $urandom_range(0, hi));
         else if (k < 96) add_req(OP_RELEASE, $urandom_range(0, hi));
         else if (k < 98) add_req(OP_CLEAR, $urandom_range(0, 15));
         else add_req(op_type'(OP_NONE), $urandom_range(0, 15));
      end
   endtask

   initial begin
      m_idctr = '0;
      foreach (m_ids[i]) m_ids[i] = '0;
      foreach (m_ring[i]) m_ring[i] = '0;
      m_pool_reg = 16;
      m_ring_reg = 16;
      pool_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation, empty queue, no latest, release of a free slot
      add_req(OP_CONS_Q, 0);
      add_req(OP_CONS_L, 0);
      add_req(OP_RELEASE, 3);
      add_req(OP_ALLOC, 15);
      add_req(OP_PUSH, 0);
      add_req(OP_CONS_Q, 0);
      add_req(OP_CONS_L, 0);
      add_req(OP_ADDREF, 9);
      add_req(OP_RELEASE, 9);
      add_req(OP_RELEASE, 0);
      add_req(OP_RELEASE, 0);
      add_req(OP_RELEASE, 0);
      add_req(OP_RELEASE, 0);
      add_req(op_type'(OP_NONE), 15);
      add_req(OP_CLEAR, 5);
      drain();

      // Small pool, tiny ring: exhaust frames, fill queue, bad index
      csr_set(CSR_POOL_IN_USE, 2);
      csr_set(CSR_QUEUE_SLOTS, 2);
      add_req(OP_ALLOC, 0);
      add_req(OP_ALLOC, 0);
      add_req(OP_ALLOC, 0);
      add_req(OP_PUSH, 1);
      add_req(OP_PUSH, 0);
      add_req(OP_PUSH, 2);
      add_req(OP_ADDREF, 15);
      add_req(OP_RELEASE, 15);
      drain();

      // Saturate a count: 260 add-references to one slot
      for (int i = 0; i < 260; i++) add_req(OP_ADDREF, 1);
      add_req(OP_CONS_L, 0);
      add_req(OP_PUSH, 1);
      add_req(OP_CONS_Q, 0);
      drain();

      // Out-of-range register values, then a series of settings
      csr_set(CSR_POOL_IN_USE, 0);
      csr_set(CSR_QUEUE_SLOTS, 31);
      random_batch(60);
      drain();
      csr_set(CSR_POOL_IN_USE, 31);
      csr_set(CSR_QUEUE_SLOTS, 0);
      random_batch(60);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         csr_set(CSR_POOL_IN_USE, 5'($urandom_range(1, 16)));
         csr_set(CSR_QUEUE_SLOTS, 5'($urandom_range(2, 16)));
         random_batch(120);
         // hold the sender part way through until all responses are back
         while (pending_reqs.size() > 60) @(posedge clock);
         hold_off = 1'b1;
         @(posedge clock);
         while (expected_rsps.size() != 0 || req_valid) @(posedge clock);
         repeat (20) @(posedge clock);
         hold_off = 1'b0;
         drain();
      end
      csr_set(CSR_POOL_IN_USE, 16);
      csr_set(CSR_QUEUE_SLOTS, 16);
      random_batch(50);
      drain();

      // Final stretch with no idling on either side
      quiet = 1'b1;
      random_batch(100);
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("refcounted_frame_pool_queue_tb: done, clean");
      else $display("refcounted_frame_pool_queue_tb: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("refcounted_frame_pool_queue_tb: done, errors");
      $finish;
   end

endmodule
